@@ sv/dspm_pkg.sv @@
// ----------------------------------------------------------------------------
// dspm_pkg
// Shared types and constants for the dot-star pattern matcher: token store
// size, position-set widths, special pattern bytes and command codes.
// ----------------------------------------------------------------------------
package dspm_pkg;

  // Token store capacity (1 .. 64)
  localparam int MAX_TOKENS = 16;

  // Position set holds one bit per token boundary
  localparam int POS_W = MAX_TOKENS + 1;
  // Token count runs 0 .. MAX_TOKENS
  localparam int CNT_W = $clog2(MAX_TOKENS + 1);
  // Index into the token store
  localparam int IDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

  // Stream widths
  localparam int SYM_W      = 8;
  localparam int CMD_W      = 2;
  localparam int OUT_DATA_W = 8;

  // Special pattern bytes
  localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DOT  = 8'h2E;

  // Item kinds carried on tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,  // clear pattern
    CMD_APPEND = 2'd1,  // append pattern byte
    CMD_BEGIN  = 2'd2,  // begin empty text
    CMD_TEXT   = 2'd3   // text byte
  } cmd_t;

endpackage

@@ sv/dot_star_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher
// Whole-string matcher for patterns of literal bytes, '.' and 'x*', run as a
// bit-parallel position-set automaton over a streamed text.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result item. Items are accepted
// at one per cycle, except while a result waits on the output side and the
// input register is full. Each result is offered from the result register:
// the item waits in the input register; the token compare, position-set
// update and star closure then load the result register from it.
// The closure over starred tokens is done as a single carry-propagate add,
// which is the longest path in the block. Pattern bytes go in with kind 1
// (up to MAX_TOKENS tokens; extra bytes are dropped and flagged until the
// next clear), text bytes with kind 3; kinds 0 and 2 clear the pattern or
// restart the text. The result says whether the whole text since the last
// restart matches the whole pattern. Input back-pressure only occurs while
// a result waits on the output side.
module dot_star_pattern_matcher (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dspm_pkg::SYM_W-1:0]         s_tdata,   // [7:0] symbol
  input  logic [dspm_pkg::CMD_W-1:0]         s_tuser,   // [1:0] command
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dspm_pkg::OUT_DATA_W-1:0]    m_tdata    // [0] matched,
                                                        // [1] pattern_overflow,
                                                        // [7:2] zero
);
  import dspm_pkg::*;

  // Input register
  logic             s1_valid;
  cmd_t             s1_cmd;
  logic [SYM_W-1:0] s1_sym;

  // Pattern and automaton state
  logic [SYM_W-1:0]      token_bytes [MAX_TOKENS];
  logic [MAX_TOKENS-1:0] token_starred;
  logic [CNT_W-1:0]      token_count;
  logic [POS_W-1:0]      active;
  logic                  overflow_seen;

  // Result register
  logic matched;
  logic pattern_overflow;

  // Next-state values
  logic [MAX_TOKENS-1:0] token_starred_next;
  logic [CNT_W-1:0]      token_count_next;
  logic [POS_W-1:0]      active_next;
  logic                  overflow_seen_next;
  logic                  matched_next;
  logic                  token_wr;

  logic                  out_free;
  logic                  step;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      last_idx;
  logic [CNT_W-1:0]      count_dec;
  logic [POS_W-1:0]      stepped;
  logic [POS_W-1:0]      base_set;
  logic [POS_W-1:0]      prop;
  logic [POS_W-1:0]      gen;
  logic [POS_W:0]        close_sum;
  logic [POS_W:0]        close_carry;

  // Handshake: output register frees when empty or taken
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_free;
  assign step     = s1_valid && out_free;

  assign wr_idx    = token_count[IDX_W-1:0];
  assign count_dec = token_count - CNT_W'(1);
  assign last_idx  = count_dec[IDX_W-1:0];

  // Advance the position set by one text byte
  always_comb begin
    stepped = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (active[i] && (CNT_W'(i) < token_count) &&
          (token_bytes[i] == SYM_DOT || token_bytes[i] == s1_sym)) begin
        if (token_starred[i]) begin
          stepped[i] = 1'b1;
        end else begin
          stepped[i+1] = 1'b1;
        end
      end
    end
  end

  // Command decode: pattern edits and choice of the unclosed position set
  always_comb begin
    token_starred_next = token_starred;
    token_count_next   = token_count;
    overflow_seen_next = overflow_seen;
    token_wr           = 1'b0;
    base_set           = POS_W'(1);
    case (s1_cmd)
      CMD_CLEAR: begin
        token_count_next   = '0;
        overflow_seen_next = 1'b0;
      end
      CMD_APPEND: begin
        if (s1_sym == SYM_STAR && token_count != '0 && !token_starred[last_idx]) begin
          token_starred_next[last_idx] = 1'b1;
        end else if (token_count < CNT_W'(MAX_TOKENS)) begin
          token_starred_next[wr_idx] = 1'b0;
          token_wr                   = 1'b1;
          token_count_next           = token_count + CNT_W'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end
      CMD_BEGIN: begin
        base_set = POS_W'(1);
      end
      default: begin
        base_set = stepped;
      end
    endcase
  end

  // Star closure: a position reaches forward across a run of starred tokens,
  // which is carry propagation with generate = set & starred
  always_comb begin
    prop = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      prop[i] = token_starred_next[i] && (CNT_W'(i) < token_count_next);
    end
    gen          = base_set & prop;
    close_sum    = {1'b0, gen} + {1'b0, prop};
    close_carry  = close_sum ^ {1'b0, gen} ^ {1'b0, prop};
    active_next  = base_set | close_carry[POS_W-1:0];
    matched_next = active_next[token_count_next];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      token_count   <= '0;
      overflow_seen <= 1'b0;
      active        <= POS_W'(1);
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (out_free) begin
        m_tvalid <= s1_valid;
      end
      if (step) begin
        token_count   <= token_count_next;
        overflow_seen <= overflow_seen_next;
        active        <= active_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_cmd <= cmd_t'(s_tuser);
      s1_sym <= s_tdata;
    end
    if (step) begin
      token_starred    <= token_starred_next;
      matched          <= matched_next;
      pattern_overflow <= overflow_seen_next;
    end
    if (step && token_wr) begin
      token_bytes[wr_idx] <= s1_sym;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-2){1'b0}}, pattern_overflow, matched};

endmodule

@@ sv/dspm_checker.sv @@
// ----------------------------------------------------------------------------
// dspm_checker
// Port-level checks for the dot-star pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
module dspm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [dspm_pkg::SYM_W-1:0]         s_tdata,
  input logic [dspm_pkg::CMD_W-1:0]         s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [dspm_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import dspm_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input is refused only while a result waits on the output side
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused without output stall");

  // A fresh result follows an item taken earlier through the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching item");

  // Padding bits of the result stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:2] == '0)
    else $error("nonzero result padding");

endmodule

bind dot_star_pattern_matcher dspm_checker u_dspm_checker (.*);
